/* rtl/core/ecpu_pkg.sv */
// shared types, constants and helpers for the euler camera pose unit
`timescale 1ns / 1ps
package ecpu_pkg;

    localparam int ANGLE_BITS_DEF      = 16;
    localparam int TRIG_ITERATIONS_DEF = 14;
    localparam int ATAN_LEN            = 24;

    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [15:0] ONE_Q14   = 16'sd16384;
    localparam logic signed [15:0] MONE_Q14  = -16'sd16384;

    typedef enum logic [2:0] {
        ACT_RESET  = 3'd0,
        ACT_SETROT = 3'd1,
        ACT_MOVEBY = 3'd2,
        ACT_MOVETO = 3'd3,
        ACT_FWD    = 3'd4,
        ACT_STRAFE = 3'd5
    } action_t;

    // datapath operation codes
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,      // latch the input item
        OP_RESET,     // restore reset state
        OP_SETROT,    // store new angles
        OP_TRIG,      // start sine/cosine for angle at trig_sel
        OP_VIEWUP,    // one product step for view/up, index idx
        OP_DIR,       // one product step for strafe direction, index idx
        OP_MOVE,      // one per-axis move step, index axis
        OP_MOVEBY,    // one per-axis add of the move vector, index axis
        OP_MOVETO     // position becomes the target
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] trig_sel;
        logic [2:0] idx;
        logic       fwd;
    } cmd_t;

    typedef struct packed {
        logic trig_busy;
    } sts_t;

    function automatic logic signed [33:0] atan_val(input int i);
        logic signed [33:0] t;
        case (i)
            0:  t = 34'sh20000000;
            1:  t = 34'sh12E4051E;
            2:  t = 34'sh09FB385B;
            3:  t = 34'sh051111D4;
            4:  t = 34'sh028B0D43;
            5:  t = 34'sh0145D7E1;
            6:  t = 34'sh00A2F61E;
            7:  t = 34'sh00517C55;
            8:  t = 34'sh0028BE53;
            9:  t = 34'sh00145F2F;
            10: t = 34'sh000A2F98;
            11: t = 34'sh000517CC;
            12: t = 34'sh00028BE6;
            13: t = 34'sh000145F3;
            14: t = 34'sh0000A2FA;
            15: t = 34'sh0000517D;
            16: t = 34'sh000028BE;
            17: t = 34'sh0000145F;
            18: t = 34'sh00000A30;
            19: t = 34'sh00000518;
            20: t = 34'sh0000028C;
            21: t = 34'sh00000146;
            22: t = 34'sh000000A3;
            23: t = 34'sh00000051;
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic signed [15:0] clamp_q14(input logic signed [35:0] v);
        if (v > 36'sd16384)
            return ONE_Q14;
        else if (v < -36'sd16384)
            return MONE_Q14;
        else
            return v[15:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -34'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

/* rtl/core/ecpu_cordic.sv */
// iterative cordic sine/cosine, one rotation per cycle, q1.14 results
`timescale 1ns / 1ps
module ecpu_cordic
    import ecpu_pkg::*;
#(
    parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
    parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [ANGLE_BITS-1:0]  angle,
    output logic                   busy,
    output logic signed [15:0]     sin_out,
    output logic signed [15:0]     cos_out
);

    localparam int NIT = (TRIG_ITERATIONS < ATAN_LEN) ? TRIG_ITERATIONS : ATAN_LEN;
    localparam int IW  = $clog2(NIT + 1);

    logic signed [33:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic               neg_reg, neg_next;
    logic [IW-1:0]      it_reg, it_next;
    logic               busy_reg, busy_next;
    logic signed [15:0] sin_reg, sin_next, cos_reg, cos_next;

    logic [31:0]        phase;
    logic [31:0]        phase_adj;
    logic               neg_q;
    logic signed [33:0] xs, ys, xr, yr;
    logic signed [15:0] cx, sy;

    assign phase     = {angle, {(32 - ANGLE_BITS){1'b0}}};
    assign neg_q     = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
    assign phase_adj = neg_q ? (phase + 32'h80000000) : phase;
    assign xs        = x_reg >>> it_reg;
    assign ys        = y_reg >>> it_reg;
    assign xr        = (x_reg + 34'sd32768) >>> 16;
    assign yr        = (y_reg + 34'sd32768) >>> 16;
    assign cx        = clamp_q14({{2{xr[33]}}, xr});
    assign sy        = clamp_q14({{2{yr[33]}}, yr});

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        neg_next  = neg_reg;
        it_next   = it_reg;
        busy_next = busy_reg;
        sin_next  = sin_reg;
        cos_next  = cos_reg;
        if (start)
        begin
            x_next    = CORDIC_X0;
            y_next    = '0;
            z_next    = {{2{phase_adj[31]}}, phase_adj};
            neg_next  = neg_q;
            it_next   = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (it_reg == IW'(NIT))
            begin
                busy_next = 1'b0;
                cos_next  = neg_reg ? -cx : cx;
                sin_next  = neg_reg ? -sy : sy;
            end
            else
            begin
                if (!z_reg[33])
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_val(int'(it_reg));
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_val(int'(it_reg));
                end
                it_next = it_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            it_reg   <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        neg_reg <= neg_next;
        sin_reg <= sin_next;
        cos_reg <= cos_next;
    end

    assign busy    = busy_reg;
    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

/* rtl/core/ecpu_datapath.sv */
// pose state, shared multipliers and sine/cosine unit
`timescale 1ns / 1ps
module ecpu_datapath
    import ecpu_pkg::*;
#(
    parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
    parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [175:0]       in_data,
    output logic [2:0][31:0]   pos_out,
    output logic [2:0][15:0]   view_out,
    output logic [2:0][15:0]   up_out
);

    logic signed [31:0] pos_reg [3];
    logic [15:0]        rot_reg [3];
    logic signed [15:0] view_reg [3];
    logic signed [15:0] up_reg [3];
    logic signed [15:0] sc_reg [6];   // sx cx sy cy sz cz
    logic signed [31:0] vin_reg [3];
    logic signed [31:0] dist_reg;
    logic [15:0]        ain_reg [3];
    logic signed [31:0] dir_reg [3];  // q2.28, fits 32 bits

    logic               trig_start, trig_busy;
    logic signed [15:0] tsin, tcos;
    logic [ANGLE_BITS-1:0] tang;

    assign tang = ANGLE_BITS'(rot_reg[cmd.trig_sel]);
    assign trig_start = (cmd.op == OP_TRIG);

    ecpu_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic
    (
        .clk(clk), .rst_n(rst_n), .start(trig_start), .angle(tang),
        .busy(trig_busy), .sin_out(tsin), .cos_out(tcos)
    );
    assign sts.trig_busy = trig_busy;

    logic trig_busy_d;
    logic [1:0] trig_sel_d;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            trig_busy_d <= 1'b0;
        else
            trig_busy_d <= trig_busy;
    end
    always_ff @(posedge clk)
    begin
        if (trig_start)
            trig_sel_d <= cmd.trig_sel;
    end

    // 16x16 products for view/up and strafe direction
    logic signed [15:0] ma, mb, mc, md;
    logic signed [31:0] p1, p2;
    logic signed [31:0] pr;
    always_comb
    begin
        ma = '0;
        mb = '0;
        mc = '0;
        md = '0;
        if (cmd.op == OP_DIR)
        begin
            case (cmd.idx)
                3'd0:
                begin
                    ma = sc_reg[1];
                    mb = sc_reg[5];
                    mc = sc_reg[2];
                    md = sc_reg[4];
                end
                3'd1:
                begin
                    ma = sc_reg[0];
                    mb = sc_reg[5];
                    mc = sc_reg[0];
                    md = sc_reg[4];
                end
                default:
                begin
                    ma = sc_reg[4];
                    mb = sc_reg[3];
                end
            endcase
        end
        else
        begin
            case (cmd.idx)
                3'd0:
                begin
                    ma = sc_reg[0];
                    mb = sc_reg[3];
                end
                3'd1:
                begin
                    ma = sc_reg[1];
                    mb = sc_reg[3];
                end
                3'd2:
                begin
                    ma = sc_reg[1];
                    mb = sc_reg[4];
                end
                3'd3:
                begin
                    ma = sc_reg[0];
                    mb = sc_reg[4];
                end
                default: ;
            endcase
        end
    end
    assign p1 = ma * mb;
    assign p2 = mc * md;
    assign pr = (p1 + 32'sd8192) >>> 14;

    // 32x16 or 32x32 move product
    logic [1:0]         ax;
    logic signed [31:0] mfac;
    logic signed [63:0] mp;
    logic signed [33:0] mstep, msum;
    assign ax   = cmd.idx[1:0];
    assign mfac = cmd.fwd ? 32'(view_reg[ax]) : dir_reg[ax];
    assign mp   = 64'(mfac) * 64'(dist_reg);
    always_comb
    begin
        if (cmd.op == OP_MOVEBY)
            mstep = 34'(vin_reg[ax]);
        else if (cmd.fwd)
            mstep = 34'((mp + 64'sd8192) >>> 14);
        else
            mstep = 34'((mp + 64'sd134217728) >>> 28);
    end
    assign msum = 34'(pos_reg[ax]) + mstep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pos_reg[k]  <= '0;
                rot_reg[k]  <= '0;
                view_reg[k] <= '0;
                up_reg[k]   <= '0;
            end
            view_reg[1] <= ONE_Q14;
            up_reg[2]   <= ONE_Q14;
        end
        else
        begin
            unique case (cmd.op) inside
                OP_RESET:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        pos_reg[k]  <= '0;
                        rot_reg[k]  <= '0;
                        view_reg[k] <= '0;
                        up_reg[k]   <= '0;
                    end
                    view_reg[1] <= ONE_Q14;
                    up_reg[2]   <= ONE_Q14;
                end
                OP_SETROT:
                    for (int k = 0; k < 3; k++)
                        rot_reg[k] <= ain_reg[k];
                OP_VIEWUP:
                begin
                    case (cmd.idx)
                        3'd0: view_reg[0] <= clamp_q14(36'(pr));
                        3'd1: view_reg[1] <= clamp_q14(36'(pr));
                        3'd2: up_reg[0]   <= clamp_q14(36'(pr));
                        3'd3: up_reg[1]   <= clamp_q14(36'(pr));
                        default:
                        begin
                            view_reg[2] <= sc_reg[2];
                            up_reg[2]   <= sc_reg[5];
                        end
                    endcase
                end
                OP_MOVE, OP_MOVEBY:
                    pos_reg[ax] <= sat32(msum);
                OP_MOVETO:
                    for (int k = 0; k < 3; k++)
                        pos_reg[k] <= vin_reg[k];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            vin_reg[0] <= in_data[31:0];
            vin_reg[1] <= in_data[63:32];
            vin_reg[2] <= in_data[95:64];
            dist_reg   <= in_data[127:96];
            ain_reg[0] <= in_data[143:128];
            ain_reg[1] <= in_data[159:144];
            ain_reg[2] <= in_data[175:160];
        end
        if (trig_busy_d && !trig_busy)
        begin
            sc_reg[{trig_sel_d, 1'b0}] <= tsin;
            sc_reg[{trig_sel_d, 1'b1}] <= tcos;
        end
        if (cmd.op == OP_DIR)
        begin
            case (cmd.idx)
                3'd0: dir_reg[0] <= p1 + p2;
                3'd1: dir_reg[1] <= p2 - p1;
                default: dir_reg[2] <= -p1;
            endcase
        end
    end

    assign pos_out[0]  = pos_reg[0];
    assign pos_out[1]  = pos_reg[1];
    assign pos_out[2]  = pos_reg[2];
    assign view_out[0] = view_reg[0];
    assign view_out[1] = view_reg[1];
    assign view_out[2] = view_reg[2];
    assign up_out[0]   = up_reg[0];
    assign up_out[1]   = up_reg[1];
    assign up_out[2]   = up_reg[2];

endmodule

/* rtl/core/ecpu_ctrl.sv */
// sequencer for the camera pose unit
`timescale 1ns / 1ps
module ecpu_ctrl
    import ecpu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic [2:0] in_action,
    input  logic       out_fire,
    input  sts_t       sts,
    output cmd_t       cmd,
    output logic       in_ready,
    output logic       out_valid
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DEC  = 7'b0000010,
        S_TRIG = 7'b0000100,
        S_WAIT = 7'b0001000,
        S_PROD = 7'b0010000,
        S_MOVE = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] act_reg, act_next;
    logic [1:0] tsel_reg, tsel_next;
    logic [2:0] idx_reg, idx_next;
    logic       first_reg, first_next;

    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        tsel_next  = tsel_reg;
        idx_next   = idx_reg;
        first_next = first_reg;
        cmd        = '{op: OP_NONE, trig_sel: tsel_reg, idx: idx_reg,
                       fwd: (act_reg == ACT_FWD)};
        unique case (state_reg)
            S_IDLE:
                if (in_fire)
                begin
                    cmd.op     = OP_LOAD;
                    act_next   = in_action;
                    state_next = S_DEC;
                end
            S_DEC:
            begin
                tsel_next  = '0;
                idx_next   = '0;
                state_next = S_OUT;
                case (act_reg) inside
                    ACT_RESET:  cmd.op = OP_RESET;
                    ACT_SETROT:
                    begin
                        cmd.op     = OP_SETROT;
                        state_next = S_TRIG;
                    end
                    ACT_MOVEBY, ACT_FWD: state_next = S_MOVE;
                    ACT_MOVETO: cmd.op = OP_MOVETO;
                    ACT_STRAFE: state_next = S_TRIG;
                    default: ;
                endcase
            end
            S_TRIG:
            begin
                cmd.op     = OP_TRIG;
                first_next = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                first_next = 1'b0;
                // result register loads the cycle busy drops
                if (!first_reg && !sts.trig_busy)
                begin
                    if (tsel_reg == 2'd2)
                        state_next = S_PROD;
                    else
                    begin
                        tsel_next  = tsel_reg + 1'b1;
                        state_next = S_TRIG;
                    end
                end
            end
            S_PROD:
            begin
                cmd.op = (act_reg == ACT_SETROT) ? OP_VIEWUP : OP_DIR;
                if ((act_reg == ACT_SETROT && idx_reg == 3'd4) ||
                    (act_reg != ACT_SETROT && idx_reg == 3'd2))
                begin
                    idx_next   = '0;
                    state_next = (act_reg == ACT_SETROT) ? S_OUT : S_MOVE;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_MOVE:
            begin
                cmd.op = (act_reg == ACT_MOVEBY) ? OP_MOVEBY : OP_MOVE;
                if (idx_reg == 3'd2)
                    state_next = S_OUT;
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_OUT:
                if (out_fire)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            act_reg   <= '0;
            tsel_reg  <= '0;
            idx_reg   <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            act_reg   <= act_next;
            tsel_reg  <= tsel_next;
            idx_reg   <= idx_next;
            first_reg <= first_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

endmodule

/* rtl/core/euler_camera_pose_unit_core.sv */
// top level of the euler camera pose unit
// A slave stream (s_axis_*) takes one item per action: tuser holds the 3-bit
// action, tdata holds vec_x, vec_y, vec_z, distance, angle_x, angle_y,
// angle_z. A master stream (m_axis_*) returns one item per action with the
// position, view vector and up vector after that step.
// Items are worked one at a time by a sequencer over a shared iterative
// sine/cosine unit and shared multipliers. Reset, move to and unused actions
// go straight to the result; move by and forward first take one move step
// per axis; set rotation and strafe first run the sine/cosine unit once per
// angle, TRIG_ITERATIONS rotations each, then their product steps, and
// strafe then its move steps. The next item is accepted only after the
// result is taken.
// The result is held in the state registers until m_axis_tready takes it;
// while the receiver stalls no new item is accepted.
// Reset puts the pose to position zero, angles zero, view (0,1,0) and
// up (0,0,1) in q1.14, with no result pending.
`timescale 1ns / 1ps
module euler_camera_pose_unit_core
    import ecpu_pkg::*;
#(
    parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
    parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // vec_x, vec_y, vec_z, distance, angle_x, angle_y, angle_z
    input  logic [175:0] s_axis_tdata,
    // action
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pos_x, pos_y, pos_z, view_x, view_y, view_z, up_x, up_y, up_z
    output logic [191:0] m_axis_tdata
);

    cmd_t             cmd;
    sts_t             sts;
    logic [2:0][31:0] pos_w;
    logic [2:0][15:0] view_w, up_w;
    logic             in_fire, out_fire;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    ecpu_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_action(s_axis_tuser),
        .out_fire(out_fire), .sts(sts), .cmd(cmd),
        .in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
    );

    ecpu_datapath #(.ANGLE_BITS(ANGLE_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_dp
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .in_data(s_axis_tdata),
        .pos_out(pos_w), .view_out(view_w), .up_out(up_w)
    );

    assign m_axis_tdata = {up_w[2], up_w[1], up_w[0], view_w[2], view_w[1], view_w[0],
                           pos_w[2], pos_w[1], pos_w[0]};

    a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("ready and result valid together");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("accepted two items back to back");

endmodule
